/* rtl/bve_pkg.sv */
`default_nettype none

package bve_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 10;
    localparam int FUNC_W   = 4;
    localparam int WORD_W   = 32;
    localparam int STAT_W   = 2;
    localparam int GRP_W    = 4;
    localparam int GRP_N    = 1 << GRP_W;
    localparam int NGRP     = CAPACITY / GRP_N;
    localparam int CMP_W    = (POS_W > LEN_W) ? POS_W : LEN_W;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH   = 4'd0,
        F_POP    = 4'd1,
        F_INSERT = 4'd2,
        F_ERASE  = 4'd3,
        F_READ   = 4'd4,
        F_WRITE  = 4'd5,
        F_FRONT  = 4'd6,
        F_BACK   = 4'd7,
        F_CLEAR  = 4'd8,
        F_RESIZE = 4'd9,
        F_ASSIGN = 4'd10
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        C_HOLD,
        C_WRITE,
        C_INS,
        C_DEL,
        C_FILL
    } cell_op_t;

    typedef struct packed {
        cell_op_t           kind;
        logic [LEN_W-1:0]   lo;
        logic [LEN_W-1:0]   hi;
        word_t              value;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_PICK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/bve_cell.sv */
`default_nettype none

module bve_cell (
    input  wire logic                    clk,
    input  wire logic [bve_pkg::LEN_W-1:0] cell_idx,
    input  wire bve_pkg::cell_ctl_t      ctl,
    input  wire bve_pkg::word_t          left,
    input  wire bve_pkg::word_t          right,
    output bve_pkg::word_t               q
);
    import bve_pkg::*;

    word_t entry_reg;
    word_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.kind)
            C_WRITE:
            begin
                if (cell_idx == ctl.lo)
                begin
                    entry_next = ctl.value;
                end
            end
            C_INS:
            begin
                if (cell_idx == ctl.lo)
                begin
                    entry_next = ctl.value;
                end
                else if (cell_idx > ctl.lo && cell_idx <= ctl.hi)
                begin
                    entry_next = left;
                end
            end
            C_DEL:
            begin
                if (cell_idx >= ctl.lo && cell_idx < ctl.hi)
                begin
                    entry_next = right;
                end
            end
            C_FILL:
            begin
                if (cell_idx < ctl.hi)
                begin
                    entry_next = ctl.value;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

/* rtl/bve_sel.sv */
`default_nettype none

module bve_sel (
    input  wire logic                      clk,
    input  wire bve_pkg::word_t            words [bve_pkg::GRP_N],
    input  wire logic [bve_pkg::GRP_W-1:0] sel,
    output bve_pkg::word_t                 q
);
    import bve_pkg::*;

    word_t q_reg;
    word_t q_next;

    assign q_next = words[sel];

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* rtl/bounded_vector_engine_unit.sv */
// Fixed-capacity ordered list of signed 32-bit words, one word per cell in a chain.
// A transaction is accepted at a rising edge where start is high and busy is low.
// It carries func, position, new_length and value. Each transaction gives exactly
// one result, shown for one cycle while done is high, on data, status, length and
// is_empty. The receiver cannot stall, so a result is simply taken in that cycle.
// The list update happens at the accepting edge, then a two-level registered select
// tree (sixteen-way per level) fetches the read word in states S_GATHER and S_PICK,
// and done is high in S_DONE. Inserts and erases shift the cells from the position
// on at once in the accepting cycle. The next transaction may be accepted in the
// cycle in which done is high; busy is high until then.
// Reset clears the length to zero; the cell contents are not cleared, and an
// entry exposed by a growing resize keeps what it held before.
// No clearing pass is needed after reset.
`default_nettype none

module bounded_vector_engine_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [bve_pkg::FUNC_W-1:0]   func,
    input  wire logic [bve_pkg::POS_W-1:0]    position,
    input  wire logic [bve_pkg::POS_W-1:0]    new_length,
    input  wire logic signed [bve_pkg::WORD_W-1:0] value,
    output logic                              done,
    output logic signed [bve_pkg::WORD_W-1:0] data,
    output logic [bve_pkg::STAT_W-1:0]        status,
    output logic [bve_pkg::LEN_W-1:0]         length,
    output logic                              is_empty
);
    import bve_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_next;
    status_t           status_reg;
    status_t           status_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;
    logic              rd_en_reg;
    logic              rd_en_next;
    word_t             data_reg;
    word_t             data_next;

    cell_ctl_t         ctl;
    logic              accept;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  req_x;
    logic              in_range;
    logic              full;
    logic              empty;
    logic              over;
    logic [LEN_W-1:0]  clamp_len;
    logic [LEN_W-1:0]  ins_lo;
    logic [LEN_W-1:0]  cnt_m1;

    word_t             cell_q [CAPACITY];
    word_t             grp_q  [NGRP];
    word_t             picked;

    assign busy      = (state_reg == S_GATHER) || (state_reg == S_PICK);
    assign accept    = start && !busy;
    assign pos_x     = CMP_W'(position);
    assign cnt_x     = CMP_W'(count_reg);
    assign req_x     = CMP_W'(new_length);
    assign in_range  = pos_x < cnt_x;
    assign full      = count_reg == LEN_W'(CAPACITY);
    assign empty     = count_reg == '0;
    assign over      = req_x > CMP_W'(CAPACITY);
    assign clamp_len = over ? LEN_W'(CAPACITY) : LEN_W'(req_x);
    assign ins_lo    = (pos_x > cnt_x) ? count_reg : LEN_W'(pos_x);
    assign cnt_m1    = count_reg - LEN_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rd_idx_next = rd_idx_reg;
        rd_en_next  = rd_en_reg;
        data_next   = data_reg;
        ctl.kind    = C_HOLD;
        ctl.lo      = '0;
        ctl.hi      = '0;
        ctl.value   = value;
        done        = 1'b0;

        case (state_reg)
            S_GATHER:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                data_next  = rd_en_reg ? picked : '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (accept)
        begin
            state_next  = S_GATHER;
            status_next = ST_OK;
            rd_en_next  = 1'b0;
            rd_idx_next = '0;
            case (func_t'(func))
                F_PUSH:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.kind   = C_WRITE;
                        ctl.lo     = count_reg;
                        count_next = count_reg + LEN_W'(1);
                    end
                end
                F_POP:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next  = cnt_m1;
                        rd_idx_next = cnt_m1[IDX_W-1:0];
                        rd_en_next  = 1'b1;
                    end
                end
                F_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.kind   = C_INS;
                        ctl.lo     = ins_lo;
                        ctl.hi     = count_reg;
                        count_next = count_reg + LEN_W'(1);
                    end
                end
                F_ERASE:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.kind   = C_DEL;
                        ctl.lo     = LEN_W'(pos_x);
                        ctl.hi     = cnt_m1;
                        count_next = cnt_m1;
                    end
                end
                F_READ:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_idx_next = pos_x[IDX_W-1:0];
                        rd_en_next  = 1'b1;
                    end
                end
                F_WRITE:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.kind = C_WRITE;
                        ctl.lo   = LEN_W'(pos_x);
                    end
                end
                F_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en_next = 1'b1;
                    end
                end
                F_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_idx_next = cnt_m1[IDX_W-1:0];
                        rd_en_next  = 1'b1;
                    end
                end
                F_CLEAR:
                begin
                    count_next = '0;
                end
                F_RESIZE:
                begin
                    count_next = clamp_len;
                    if (over)
                    begin
                        status_next = ST_FULL;
                    end
                end
                F_ASSIGN:
                begin
                    count_next = clamp_len;
                    ctl.kind   = C_FILL;
                    ctl.hi     = clamp_len;
                    if (over)
                    begin
                        status_next = ST_FULL;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ST_OK;
            rd_en_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            rd_en_reg  <= rd_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        data_reg   <= data_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            bve_cell u_cell (
                .clk      (clk),
                .cell_idx (LEN_W'(gi)),
                .ctl      (ctl),
                .left     ((gi == 0) ? word_t'('0) : cell_q[(gi == 0) ? 0 : gi - 1]),
                .right    ((gi == CAPACITY - 1) ? word_t'('0)
                           : cell_q[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .q        (cell_q[gi])
            );
        end

        for (gi = 0; gi < NGRP; gi++)
        begin : g_grp
            word_t grp_words [GRP_N];
            genvar gj;
            for (gj = 0; gj < GRP_N; gj++)
            begin : g_word
                assign grp_words[gj] = cell_q[gi * GRP_N + gj];
            end

            bve_sel u_sel (
                .clk   (clk),
                .words (grp_words),
                .sel   (rd_idx_reg[GRP_W-1:0]),
                .q     (grp_q[gi])
            );
        end
    endgenerate

    assign picked   = grp_q[rd_idx_reg[IDX_W-1:GRP_W]];

    assign data     = data_reg;
    assign status   = status_reg;
    assign length   = count_reg;
    assign is_empty = (count_reg == '0);

    a_done_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_PICK))
        else $error("result strobe without a finished select");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg <= LEN_W'(CAPACITY)))
        else $error("length above capacity");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (data == '0))
        else $error("nonzero data with a failing status");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("transaction not held busy after acceptance");

endmodule

`default_nettype wire
